[rtl/core/mexp_pkg.sv]
// Shared types and constants for the modular exponentiation block.
// No dependencies; imported by mexp_mulmod, modular_exponentiation and the testbench.
package mexp_pkg;

    // Fixed widths of the external ports
    localparam int DATA_BITS    = 64;
    localparam int CFG_IDX_BITS = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_EXPONENT = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MODULUS  = 2'd1;

    // Register reset values
    localparam logic [DATA_BITS-1:0] EXPONENT_RESET = 64'd65537;
    localparam logic [DATA_BITS-1:0] MODULUS_RESET  = 64'd1;

    // Top-level sequencer states
    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_REDUCE = 5'b00010,
        S_LAUNCH = 5'b00100,
        S_WAIT   = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    // Modular multiplier states
    typedef enum logic [2:0] {
        M_IDLE = 3'b001,
        M_PREP = 3'b010,
        M_RUN  = 3'b100
    } t_mul_state;

    // Multiplier status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_status;

endpackage

[rtl/core/mexp_mulmod.sv]
// Bit-serial modular multiplier: (a * b) mod m, MSB-first shift-and-add.
// Depends on mexp_pkg. Expects a < m; b may be any value.
module mexp_mulmod
    import mexp_pkg::*;
#(
    parameter int WORD_BITS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [WORD_BITS-1:0] i_mult_a,
    input  logic [WORD_BITS-1:0] i_mult_b,
    input  logic [WORD_BITS-1:0] i_modulus,
    output t_mul_status          o_status,
    output logic [WORD_BITS-1:0] o_product
);

    localparam int XW = WORD_BITS + 3;
    localparam int CW = $clog2(WORD_BITS);
    localparam logic [CW-1:0] LAST_STEP = CW'(WORD_BITS - 1);

    t_mul_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic r_done, n_done;

    logic [WORD_BITS-1:0] r_a, r_b, r_m, r_acc;
    logic signed [XW-1:0] r_am1, r_am2, r_nm1, r_nm2;

    logic signed [XW-1:0] ext_a, ext_m;
    logic signed [XW-1:0] dbl, c0, c1, c2, s0, s1, s2;
    logic                 bit_b;
    logic [WORD_BITS-1:0] step_acc;

    assign ext_a = {3'b000, r_a};
    assign ext_m = {3'b000, r_m};

    // One step: acc = 2*acc + bit*a, reduced by 0, m or 2m in parallel
    always_comb begin
        bit_b = r_b[WORD_BITS-1];
        dbl   = {2'b00, r_acc, 1'b0};
        c0    = bit_b ? ext_a : '0;
        c1    = bit_b ? r_am1 : r_nm1;
        c2    = bit_b ? r_am2 : r_nm2;
        s0    = dbl + c0;
        s1    = dbl + c1;
        s2    = dbl + c2;
        if (!s2[XW-1]) begin
            step_acc = s2[WORD_BITS-1:0];
        end else if (!s1[XW-1]) begin
            step_acc = s1[WORD_BITS-1:0];
        end else begin
            step_acc = s0[WORD_BITS-1:0];
        end
    end

    // Sequence: load, precompute offsets, then one multiplier bit per cycle
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        case (r_state)
            M_IDLE: begin
                if (i_start) begin
                    n_state = M_PREP;
                end
            end
            M_PREP: begin
                n_state = M_RUN;
                n_cnt   = '0;
            end
            M_RUN: begin
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == LAST_STEP) begin
                    n_state = M_IDLE;
                    n_done  = 1'b1;
                end
            end
            default: begin
                n_state = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
    end

    // Operand and accumulator registers
    always_ff @(posedge i_clk) begin
        if (r_state == M_IDLE && i_start) begin
            r_a   <= i_mult_a;
            r_b   <= i_mult_b;
            r_m   <= i_modulus;
            r_acc <= '0;
        end
        if (r_state == M_PREP) begin
            r_am1 <= ext_a - ext_m;
            r_am2 <= ext_a - (ext_m <<< 1);
            r_nm1 <= -ext_m;
            r_nm2 <= -(ext_m <<< 1);
        end
        if (r_state == M_RUN) begin
            r_acc <= step_acc;
            r_b   <= r_b << 1;
        end
    end

    assign o_status.busy = (r_state != M_IDLE);
    assign o_status.done = r_done;
    assign o_product     = r_acc;

    // The accumulator stays reduced through the whole run
    a_acc_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == M_RUN) |-> (r_acc < r_m))
        else $error("mulmod accumulator not below modulus");

    // Offsets are precomputed in the prep state, which the run state follows directly
    a_prep_to_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == M_PREP) |=> (r_state == M_RUN))
        else $error("mulmod prep not followed by run");

    // Done is only flagged once the run is over
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == M_IDLE))
        else $error("mulmod done while still running");

endmodule

[rtl/core/modular_exponentiation.sv]
// Modular exponentiation top level: base ^ exponent mod modulus.
// Depends on mexp_pkg and mexp_mulmod (two instances).
//
// Usage:
//   Input channel (i_valid / o_stall / i_base_value): one word per transaction,
//   taken while the block is idle; o_stall is high while a word is in work.
//   Output channel (o_valid / i_stall / o_power_result): one result per input.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data):
//   index 0 writes the exponent, index 1 the modulus (a zero write is
//   dropped, a zero modulus after masking acts as 1). Write only when idle.
// Operation: the base is first reduced in one multiplier pass; each exponent
//   bit up to the highest set one then takes one further pass, in which the
//   multiply and the square run side by side on two bit-serial multipliers
//   that handle one multiplier bit per cycle. A zero exponent skips the
//   multiplier passes and returns 1.
// Reset (synchronous, active low) returns exponent to 65537, modulus to 1,
//   and drops any word in work. A stalled result is held in the output
//   register; the next word is accepted meanwhile and waits at the end of
//   its computation until that register frees.
module modular_exponentiation
    import mexp_pkg::*;
#(
    parameter int WORD_BITS = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [DATA_BITS-1:0]    i_base_value,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [DATA_BITS-1:0]    o_power_result,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [DATA_BITS-1:0]    i_cfg_data
);

    localparam logic [WORD_BITS-1:0] ONE = WORD_BITS'(1);

    t_state r_state, n_state;
    logic   r_out_valid;

    logic [WORD_BITS-1:0] r_exponent, r_modulus;
    logic [WORD_BITS-1:0] r_mod_eff, r_exp, r_base, r_result, r_out;

    logic                 accept, cfg_write, out_free;
    logic [WORD_BITS-1:0] mod_now, one_now, one_red;

    logic                 sq_start, mul_start;
    logic [WORD_BITS-1:0] sq_a, sq_b, sq_m, sq_prod, mul_prod;
    t_mul_status          sq_st, mul_st;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;
    assign o_stall     = (r_state != S_IDLE);
    assign accept      = i_valid && !o_stall;
    assign out_free    = !r_out_valid || !i_stall;

    // Effective modulus and reduced one from the registers as they stand
    assign mod_now = (r_modulus == '0) ? ONE : r_modulus;
    assign one_now = (mod_now == ONE) ? '0 : ONE;
    assign one_red = (r_mod_eff == ONE) ? '0 : ONE;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exponent <= EXPONENT_RESET[WORD_BITS-1:0];
            r_modulus  <= MODULUS_RESET[WORD_BITS-1:0];
        end else if (cfg_write) begin
            case (i_cfg_index)
                REG_EXPONENT: r_exponent <= i_cfg_data[WORD_BITS-1:0];
                REG_MODULUS: begin
                    if (i_cfg_data != '0) begin
                        r_modulus <= i_cfg_data[WORD_BITS-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // Multiplier operands: base reduction at accept, square of base and multiply start later
    always_comb begin
        sq_start  = 1'b0;
        mul_start = 1'b0;
        sq_a      = r_base;
        sq_b      = r_base;
        sq_m      = r_mod_eff;
        if (accept && r_exponent != '0) begin
            sq_start = 1'b1;
            sq_a     = one_now;
            sq_b     = i_base_value[WORD_BITS-1:0];
            sq_m     = mod_now;
        end else if (r_state == S_LAUNCH) begin
            sq_start  = 1'b1;
            mul_start = 1'b1;
        end
    end

    mexp_mulmod #(
        .WORD_BITS (WORD_BITS)
    ) u_square (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (sq_start),
        .i_mult_a  (sq_a),
        .i_mult_b  (sq_b),
        .i_modulus (sq_m),
        .o_status  (sq_st),
        .o_product (sq_prod)
    );

    mexp_mulmod #(
        .WORD_BITS (WORD_BITS)
    ) u_multiply (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_mult_a  (r_result),
        .i_mult_b  (r_base),
        .i_modulus (r_mod_eff),
        .o_status  (mul_st),
        .o_product (mul_prod)
    );

    // Sequencer: reduce base, then one exponent bit per multiplier pass
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (r_exponent == '0) ? S_FINISH : S_REDUCE;
                end
            end
            S_REDUCE: begin
                if (sq_st.done) begin
                    n_state = S_LAUNCH;
                end
            end
            S_LAUNCH: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (sq_st.done) begin
                    n_state = ((r_exp >> 1) == '0) ? S_FINISH : S_LAUNCH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_FINISH && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers: exponent shifter, base and running result
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_exp     <= r_exponent;
                    r_mod_eff <= mod_now;
                    r_result  <= ONE;
                end
            end
            S_REDUCE: begin
                if (sq_st.done) begin
                    r_base   <= sq_prod;
                    r_result <= one_red;
                end
            end
            S_WAIT: begin
                if (sq_st.done) begin
                    r_base <= sq_prod;
                    r_exp  <= r_exp >> 1;
                    if (r_exp[0]) begin
                        r_result <= mul_prod;
                    end
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    r_out <= r_result;
                end
            end
            default: ;
        endcase
    end

    assign o_valid        = r_out_valid;
    assign o_power_result = DATA_BITS'(r_out);

    // Both multipliers finish together once launched side by side
    a_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT) |-> (mul_st.done == sq_st.done))
        else $error("multiply and square passes out of step");

    // A new result only comes out of the finishing state
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_FINISH))
        else $error("output valid raised outside finish");

    // Every square pass leaves a reduced value
    a_square_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_st.done |-> (sq_prod < r_mod_eff))
        else $error("square result not below modulus");

    // An accepted word always leaves the idle state
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("accepted word not taken into work");

    // Multipliers are never restarted while busy
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (sq_start || mul_start) |-> (!sq_st.busy && !mul_st.busy))
        else $error("multiplier restarted while busy");

endmodule

[tb/sv/modular_exponentiation_tb.sv]
// Self-checking testbench for modular_exponentiation (base ^ exponent mod modulus).
// Depends on mexp_pkg and the RTL; a queue-fed driver and a monitor check every
// result against a built-in power predictor under random idling and stalls.
`timescale 1ns / 1ps

module modular_exponentiation_tb;
    import mexp_pkg::*;

    // Writes to these indexes must leave both registers untouched
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_3 = 2'd3;

    localparam int LONG_HOLD_CYCLES = 12000;
    localparam int WATCHDOG_LIMIT   = 40000;
    localparam int RANDOM_PHASES    = 5;
    localparam int ITEMS_PER_PHASE  = 16;

    localparam logic [DATA_BITS-1:0] ALL_ONES = {DATA_BITS{1'b1}};

    logic                    i_clk          = 1'b0;
    logic                    i_rst_n        = 1'b0;
    logic                    i_valid        = 1'b0;
    logic                    o_stall;
    logic [DATA_BITS-1:0]    i_base_value   = '0;
    logic                    o_valid;
    logic                    i_stall        = 1'b0;
    logic [DATA_BITS-1:0]    o_power_result;
    logic                    i_cfg_valid    = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index    = '0;
    logic [DATA_BITS-1:0]    i_cfg_data     = '0;

    // Mirror of the register file as seen by the predictor
    logic [DATA_BITS-1:0] cfg_exponent = EXPONENT_RESET;
    logic [DATA_BITS-1:0] cfg_modulus  = MODULUS_RESET;

    logic [DATA_BITS-1:0] pending_bases[$];
    logic [DATA_BITS-1:0] expected_powers[$];
    logic [DATA_BITS-1:0] want_power;

    // Directed words for the small key pair: extremes, wrap-around and the top bit
    logic [DATA_BITS-1:0] pick_list[9] = '{
        64'd0, 64'd1, 64'd2, 64'd65, 64'd3232, 64'd3233, 64'd3234,
        64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000
    };

    int   error_count  = 0;
    int   gap_left     = 0;
    int   stall_left   = 0;
    int   idle_cycles  = 0;
    logic quiet_tail   = 1'b0;
    logic hold_armed   = 1'b0;
    logic hold_started = 1'b0;

    modular_exponentiation DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_base_value   (i_base_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_power_result (o_power_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5;
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
    end

    // Right-to-left square-and-multiply over all exponent bits with full-width products
    function automatic logic [DATA_BITS-1:0] predict_power(
        input logic [DATA_BITS-1:0] base,
        input logic [DATA_BITS-1:0] expo,
        input logic [DATA_BITS-1:0] modv
    );
        logic [DATA_BITS-1:0]   acc;
        logic [DATA_BITS-1:0]   sq;
        logic [2*DATA_BITS-1:0] prod;
        logic [2*DATA_BITS-1:0] wide_mod;
        if (modv == '0)
            modv = DATA_BITS'(1);
        wide_mod = {{DATA_BITS{1'b0}}, modv};
        sq  = base % modv;
        acc = DATA_BITS'(1);
        for (int i = 0; i < DATA_BITS; i++) begin
            if (expo[i]) begin
                prod = {{DATA_BITS{1'b0}}, acc} * {{DATA_BITS{1'b0}}, sq};
                acc  = DATA_BITS'(prod % wide_mod);
            end
            prod = {{DATA_BITS{1'b0}}, sq} * {{DATA_BITS{1'b0}}, sq};
            sq   = DATA_BITS'(prod % wide_mod);
        end
        return acc;
    endfunction

    function automatic logic [DATA_BITS-1:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // Write one register while the block is idle, then mirror it
    task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                  input logic [DATA_BITS-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_EXPONENT)
            cfg_exponent = data;
        else if (idx == REG_MODULUS && data != '0)
            cfg_modulus = data;
    endtask

    // Wait until every queued word has gone in and every result has come back
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_bases.size() != 0 || i_valid || expected_powers.size() != 0);
    endtask

    // Driver: present queued words with random gaps, hold while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            gap_left <= 0;
        end else begin
            if (i_valid && !o_stall)
                expected_powers.push_back(
                    predict_power(i_base_value, cfg_exponent, cfg_modulus));
            if (!i_valid || !o_stall) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    i_valid  <= 1'b0;
                end else if (pending_bases.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                    gap_left <= $urandom_range(0, 13);
                    i_valid  <= 1'b0;
                end else begin
                    i_valid      <= 1'b1;
                    i_base_value <= pending_bases.pop_front();
                end
            end
        end
    end

    // Monitor: check each result transaction, drive receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall      <= 1'b0;
            stall_left   <= 0;
            hold_started <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_powers.size() == 0) begin
                    $display("%0t: unexpected result %h, none expected",
                             $time, o_power_result);
                    error_count++;
                end else begin
                    want_power = expected_powers.pop_front();
                    if (o_power_result !== want_power) begin
                        $display("%0t: power_result mismatch: expected %h, actual %h",
                                 $time, want_power, o_power_result);
                        error_count++;
                    end
                end
            end
            if (hold_armed && !hold_started) begin
                hold_started <= 1'b1;
                stall_left   <= LONG_HOLD_CYCLES;
                i_stall      <= 1'b1;
            end else if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                i_stall    <= 1'b1;
            end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                stall_left <= $urandom_range(0, 13);
                i_stall    <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog: end the run if no transaction moves on any channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((i_valid && !o_stall) || (o_valid && !i_stall)
                     || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus: directed phases first, then random configurations and words
    initial begin
        logic [DATA_BITS-1:0] word;
        logic [DATA_BITS-1:0] expo;
        logic [DATA_BITS-1:0] modv;
        int                   pick;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset registers: exponent 65537, modulus 1
        pending_bases.push_back('0);
        pending_bases.push_back(64'd1);
        pending_bases.push_back(ALL_ONES);
        wait_idle();

        // Small textbook key pair, encrypt then decrypt
        write_register(REG_EXPONENT, 64'd17);
        write_register(REG_MODULUS, 64'd3233);
        foreach (pick_list[k])
            pending_bases.push_back(pick_list[k]);
        wait_idle();
        write_register(REG_EXPONENT, 64'd2753);
        pending_bases.push_back(64'd2790);
        pending_bases.push_back(64'd1);
        wait_idle();

        // Zero exponent gives 1 even with modulus 1; a zero modulus write is dropped
        write_register(REG_EXPONENT, '0);
        write_register(REG_MODULUS, '0);
        pending_bases.push_back(64'd7);
        wait_idle();
        write_register(REG_MODULUS, 64'd1);
        write_register(REG_SPARE_2, ALL_ONES);
        write_register(REG_SPARE_3, 64'h5555_5555_5555_5555);
        pending_bases.push_back('0);
        pending_bases.push_back(ALL_ONES);
        wait_idle();

        // Largest exponent and modulus
        write_register(REG_EXPONENT, ALL_ONES);
        write_register(REG_MODULUS, ALL_ONES);
        pending_bases.push_back(ALL_ONES);
        pending_bases.push_back(ALL_ONES - 64'd1);
        pending_bases.push_back(64'd2);
        pending_bases.push_back('0);
        wait_idle();

        // Only the top exponent bit, modulus with the top bit set
        write_register(REG_EXPONENT, 64'h8000_0000_0000_0000);
        write_register(REG_MODULUS, 64'h8000_0000_0000_0001);
        pending_bases.push_back(rand_word());
        pending_bases.push_back(64'h8000_0000_0000_0000);
        wait_idle();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0:       expo = '0;
                1:       expo = ALL_ONES;
                2, 3, 4: expo = DATA_BITS'($urandom_range(1, 70000));
                default: expo = rand_word();
            endcase
            pick = $urandom_range(0, 9);
            case (pick)
                0:       modv = '0;
                1:       modv = 64'd1;
                2, 3:    modv = DATA_BITS'($urandom_range(2, 5000));
                4:       modv = ALL_ONES - DATA_BITS'($urandom_range(0, 100));
                default: modv = rand_word();
            endcase
            write_register(REG_EXPONENT, expo);
            write_register(REG_MODULUS, modv);
            if ($urandom_range(0, 1) == 0)
                write_register($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                               rand_word());
            if (phase == 1)
                hold_armed = 1'b1;
            if (phase == RANDOM_PHASES - 1)
                quiet_tail = 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick = $urandom_range(0, 9);
                case (pick)
                    0:       word = DATA_BITS'($urandom_range(0, 15));
                    1:       word = cfg_modulus - DATA_BITS'($urandom_range(0, 2));
                    2:       word = cfg_modulus + DATA_BITS'($urandom_range(0, 3));
                    3:       word = ~DATA_BITS'($urandom_range(0, 15));
                    default: word = rand_word();
                endcase
                pending_bases.push_back(word);
            end
            wait_idle();
        end

        repeat (50) @(posedge i_clk);
        if (expected_powers.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_powers.size());
            error_count++;
        end
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
